FILE: hdl/lru_slot_allocator_unit_assert.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef LRU_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define LRU_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define LSA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("slot allocator assertion failed");

// Checked at every clock edge, reset included.
`define LSA_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("slot allocator assertion failed");

`else

`define LSA_ASSERT(label, prop)
`define LSA_ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: hdl/lsa_pkg.sv
// Types and constants of the slot allocator.
package lsa_pkg;

   localparam int NUM_SLOTS   = 64;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int COUNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int SCAN_LEVELS = $clog2(NUM_SLOTS);
   localparam int ACTIVE_W    = 7;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(64);

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_TOUCH   = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STATUS_NOT_HELD = 2'd2;

   typedef logic [SLOT_W-1:0] lsa_slot_type;

   typedef struct packed {
      logic [1:0]   req_type;
      lsa_slot_type slot_id;
   } lsa_req_type;

   typedef struct packed {
      logic [1:0]   status;
      lsa_slot_type granted_slot;
      logic         evicted;
   } lsa_rsp_type;

   typedef struct packed {
      logic live;
      logic load;
      logic shift;
   } lsa_cell_ctrl_type;

endpackage

FILE: hdl/lru_slot_allocator_unit.sv
// Top level of the slot allocator with least-recently-used reclaim.
//
//   Channel  Handshake               Beat
//   req      start / busy            req_data  (req_type, slot_id)
//   rsp      rsp_strobe              rsp_data  (status, granted_slot, evicted)
//   csr      csr_valid / csr_ready   csr_data  (active_slots)
//
// A request is captured in the idle state, and in the working state the stack of cells
// compares, shifts and loads; a new request is taken only once the block is back in idle.
// The result beat is shown for one cycle after the working cycle, while busy is low.
// Synchronous reset frees every slot and sets active_slots to 64.
// The receiver cannot stall the result; csr_ready is always high.
`include "lru_slot_allocator_unit_assert.svh"

module lru_slot_allocator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  lsa_pkg::lsa_req_type               req_data,
   output logic                               rsp_strobe,
   output lsa_pkg::lsa_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lsa_pkg::ACTIVE_W-1:0]       csr_data
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type                          state_ff;
   lsa_pkg::lsa_req_type               req_ff;
   logic                               rsp_strobe_ff;
   lsa_pkg::lsa_rsp_type               rsp_data_ff;
   lsa_pkg::lsa_rsp_type               rsp_data_in;

   logic [lsa_pkg::ACTIVE_W-1:0]       active_slots_ff;
   logic [lsa_pkg::NUM_SLOTS-1:0]      held_flags_ff;
   logic [lsa_pkg::NUM_SLOTS-1:0]      held_flags_in;
   logic [lsa_pkg::COUNT_W-1:0]        held_count_ff;
   logic [lsa_pkg::COUNT_W-1:0]        held_count_in;

   lsa_pkg::lsa_slot_type              cell_id [lsa_pkg::NUM_SLOTS];
   lsa_pkg::lsa_slot_type              right_id [lsa_pkg::NUM_SLOTS];
   lsa_pkg::lsa_cell_ctrl_type         cell_ctrl [lsa_pkg::NUM_SLOTS];
   logic [lsa_pkg::NUM_SLOTS-1:0]      cell_match;
   logic [lsa_pkg::NUM_SLOTS-1:0]      scan [lsa_pkg::SCAN_LEVELS+1];

   logic [lsa_pkg::NUM_SLOTS-1:0]      avail;
   logic [lsa_pkg::NUM_SLOTS-1:0]      free_onehot;
   lsa_pkg::lsa_slot_type              free_slot;
   logic                               any_free;
   logic [lsa_pkg::NUM_SLOTS-1:0]      at_count;
   logic [lsa_pkg::NUM_SLOTS-1:0]      at_last;

   logic                               exec;
   logic                               is_alloc;
   logic                               is_touch;
   logic                               is_release;
   logic                               found;
   logic                               do_push;
   logic                               do_evict;
   logic                               do_touch;
   logic                               do_release;
   lsa_pkg::lsa_slot_type              load_id;

   // The chain of cells; entry 0 is the least recently used slot.
   for (genvar i = 0; i < lsa_pkg::NUM_SLOTS; i++) begin : g_cell
      if (i == lsa_pkg::NUM_SLOTS - 1) begin : g_end
         assign right_id[i] = '0;
      end else begin : g_mid
         assign right_id[i] = cell_id[i+1];
      end

      assign at_count[i] = (held_count_ff == lsa_pkg::COUNT_W'(i));
      assign at_last[i]  = (held_count_ff == lsa_pkg::COUNT_W'(i + 1));
      assign avail[i]    = !held_flags_ff[i] && (i < int'(active_slots_ff));

      assign cell_ctrl[i] = '{
         live:  (held_count_ff > lsa_pkg::COUNT_W'(i)),
         load:  (do_push && at_count[i]) || ((do_evict || do_touch) && at_last[i]),
         shift: do_evict || ((do_touch || do_release) && scan[lsa_pkg::SCAN_LEVELS][i])
      };

      lsa_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl[i]),
         .key      (req_ff.slot_id),
         .right_id (right_id[i]),
         .load_id  (load_id),
         .id       (cell_id[i]),
         .match    (cell_match[i])
      );
   end

   // Every cell at or after the matching entry takes its neighbour's slot.
   always_comb begin
      scan[0] = cell_match;
      for (int lv = 0; lv < lsa_pkg::SCAN_LEVELS; lv++) begin
         for (int gi = 0; gi < lsa_pkg::NUM_SLOTS; gi++) begin
            if (gi >= (1 << lv)) begin
               scan[lv+1][gi] = scan[lv][gi] | scan[lv][gi - (1 << lv)];
            end else begin
               scan[lv+1][gi] = scan[lv][gi];
            end
         end
      end
   end

   // The lowest free active slot.
   assign free_onehot = avail & (~avail + lsa_pkg::NUM_SLOTS'(1));
   assign any_free    = |avail;

   always_comb begin
      free_slot = '0;
      for (int s = 0; s < lsa_pkg::NUM_SLOTS; s++) begin
         if (free_onehot[s]) begin
            free_slot = free_slot | lsa_pkg::SLOT_W'(s);
         end
      end
   end

   always_comb begin
      exec       = (state_ff == ST_EXEC);
      is_alloc   = (req_ff.req_type == lsa_pkg::REQ_ALLOC);
      is_touch   = (req_ff.req_type == lsa_pkg::REQ_TOUCH);
      is_release = (req_ff.req_type == lsa_pkg::REQ_RELEASE);
      found      = held_flags_ff[req_ff.slot_id];
      do_push    = exec && is_alloc && any_free;
      do_evict   = exec && is_alloc && !any_free && (held_count_ff != '0);
      do_touch   = exec && is_touch && found;
      do_release = exec && is_release && found;

      priority if (do_push) begin
         load_id = free_slot;
      end else if (do_evict) begin
         load_id = cell_id[0];
      end else begin
         load_id = req_ff.slot_id;
      end

      held_flags_in = held_flags_ff;
      held_count_in = held_count_ff;
      if (do_push) begin
         held_flags_in[free_slot] = 1'b1;
         held_count_in            = held_count_ff + lsa_pkg::COUNT_W'(1);
      end
      if (do_release) begin
         held_flags_in[req_ff.slot_id] = 1'b0;
         held_count_in                 = held_count_ff - lsa_pkg::COUNT_W'(1);
      end

      rsp_data_in.granted_slot = load_id;
      rsp_data_in.evicted      = do_evict;
      unique case (req_ff.req_type)
         lsa_pkg::REQ_ALLOC: begin
            rsp_data_in.status = (any_free || (held_count_ff != '0)) ?
                                 lsa_pkg::STATUS_OK : lsa_pkg::STATUS_NO_SLOT;
         end
         lsa_pkg::REQ_TOUCH, lsa_pkg::REQ_RELEASE: begin
            rsp_data_in.status = found ? lsa_pkg::STATUS_OK : lsa_pkg::STATUS_NOT_HELD;
         end
         default: begin
            rsp_data_in.status = lsa_pkg::STATUS_NOT_HELD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_strobe_ff <= 1'b0;
               if (start) begin
                  state_ff <= ST_EXEC;
                  req_ff   <= req_data;
               end
            end
            ST_EXEC: begin
               state_ff      <= ST_IDLE;
               rsp_strobe_ff <= 1'b1;
               rsp_data_ff   <= rsp_data_in;
            end
            default: begin
               state_ff      <= ST_IDLE;
               rsp_strobe_ff <= 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_flags_ff   <= '0;
         held_count_ff   <= '0;
         active_slots_ff <= lsa_pkg::ACTIVE_RESET;
      end else begin
         held_flags_ff <= held_flags_in;
         held_count_ff <= held_count_in;
         if (csr_valid) begin
            active_slots_ff <= csr_data;
         end
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   `LSA_ASSERT(a_exec_gives_beat, state_ff == ST_EXEC |=> rsp_strobe_ff)
   `LSA_ASSERT(a_count_in_range, held_count_ff <= lsa_pkg::COUNT_W'(lsa_pkg::NUM_SLOTS))
   `LSA_ASSERT(a_flags_match_count, $countones(held_flags_ff) == int'(held_count_ff))
   `LSA_ASSERT(a_evict_keeps_count,
      rsp_strobe_ff && rsp_data_ff.evicted |-> held_count_ff == $past(held_count_ff))
   `LSA_ASSERT_ALWAYS(a_csr_always_ready, csr_ready)

endmodule

FILE: hdl/lsa_cell.sv
// One entry of the recency stack: holds a slot number and compares it with the key.
module lsa_cell (
   input  logic                      clock,
   input  lsa_pkg::lsa_cell_ctrl_type ctrl,
   input  lsa_pkg::lsa_slot_type     key,
   input  lsa_pkg::lsa_slot_type     right_id,
   input  lsa_pkg::lsa_slot_type     load_id,
   output lsa_pkg::lsa_slot_type     id,
   output logic                      match
);

   lsa_pkg::lsa_slot_type id_ff;

   always_ff @(posedge clock) begin
      priority if (ctrl.load) begin
         id_ff <= load_id;
      end else if (ctrl.shift) begin
         id_ff <= right_id;
      end else begin
         id_ff <= id_ff;
      end
   end

   assign id    = id_ff;
   assign match = ctrl.live && (id_ff == key);

endmodule

FILE: bench/lru_slot_allocator_unit_test.sv
// Self-checking testbench of the slot allocator: directed and random requests against a predictor.
module lru_slot_allocator_unit_test;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 4;
   localparam int OUTCOME_DEPTH = 8;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   lsa_pkg::lsa_req_type req_data;
   logic rsp_strobe;
   lsa_pkg::lsa_rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [lsa_pkg::ACTIVE_W-1:0] csr_data;

   lsa_pkg::lsa_slot_type lru_stack [lsa_pkg::NUM_SLOTS];
   int unsigned held_total;
   logic [lsa_pkg::NUM_SLOTS-1:0] slot_held;
   logic [lsa_pkg::ACTIVE_W-1:0] pool_size;
   lsa_pkg::lsa_rsp_type outcome_buf [OUTCOME_DEPTH];
   int unsigned outcome_wr = 0;
   int unsigned outcome_rd = 0;
   int unsigned mismatch_count = 0;

   lru_slot_allocator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic lsa_pkg::lsa_req_type make_req(logic [1:0] kind,
                                                     lsa_pkg::lsa_slot_type id);
      lsa_pkg::lsa_req_type r;
      r.req_type = kind;
      r.slot_id  = id;
      return r;
   endfunction

   function automatic void store_outcome(lsa_pkg::lsa_rsp_type o);
      outcome_buf[outcome_wr % OUTCOME_DEPTH] = o;
      outcome_wr++;
   endfunction

   function automatic lsa_pkg::lsa_rsp_type take_outcome();
      lsa_pkg::lsa_rsp_type o;
      o = outcome_buf[outcome_rd % OUTCOME_DEPTH];
      outcome_rd++;
      return o;
   endfunction

   function automatic void drop_from_stack(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < held_total; i++) begin
         lru_stack[i] = lru_stack[i + 1];
      end
      held_total--;
   endfunction

   // Applies one request to the predicted pool and returns the result it should give.
   function automatic lsa_pkg::lsa_rsp_type predict_outcome(lsa_pkg::lsa_req_type r);
      lsa_pkg::lsa_rsp_type o;
      int lim;
      int pick;
      int s;
      int unsigned pos;
      o.status       = lsa_pkg::STATUS_OK;
      o.granted_slot = r.slot_id;
      o.evicted      = 1'b0;
      case (r.req_type)
         lsa_pkg::REQ_ALLOC: begin
            lim  = (pool_size < lsa_pkg::NUM_SLOTS) ? int'(pool_size) : lsa_pkg::NUM_SLOTS;
            pick = -1;
            for (s = 0; s < lim && pick < 0; s++) begin
               if (!slot_held[s]) pick = s;
            end
            if (pick >= 0) begin
               slot_held[pick] = 1'b1;
               lru_stack[held_total] = lsa_pkg::lsa_slot_type'(pick);
               held_total++;
               o.granted_slot = lsa_pkg::lsa_slot_type'(pick);
            end else if (held_total > 0) begin
               o.granted_slot = lru_stack[0];
               drop_from_stack(0);
               lru_stack[held_total] = o.granted_slot;
               held_total++;
               o.evicted = 1'b1;
            end else begin
               o.status = lsa_pkg::STATUS_NO_SLOT;
            end
         end
         lsa_pkg::REQ_TOUCH, lsa_pkg::REQ_RELEASE: begin
            if (!slot_held[r.slot_id]) begin
               o.status = lsa_pkg::STATUS_NOT_HELD;
            end else begin
               pos = 0;
               while (lru_stack[pos] != r.slot_id) pos++;
               drop_from_stack(pos);
               if (r.req_type == lsa_pkg::REQ_TOUCH) begin
                  lru_stack[held_total] = r.slot_id;
                  held_total++;
               end else begin
                  slot_held[r.slot_id] = 1'b0;
               end
            end
         end
         default: begin
            o.status = lsa_pkg::STATUS_NOT_HELD;
         end
      endcase
      return o;
   endfunction

   // Mostly well-formed traffic on held slots, with some stray slot ids and unused codes.
   function automatic lsa_pkg::lsa_req_type random_request(int unsigned alloc_pct);
      int unsigned roll;
      logic [1:0] kind;
      lsa_pkg::lsa_slot_type id;
      roll = $urandom_range(99);
      id   = lsa_pkg::lsa_slot_type'($urandom_range(lsa_pkg::NUM_SLOTS - 1));
      if (roll < 3) begin
         kind = REQ_UNUSED;
      end else if (roll < alloc_pct) begin
         kind = lsa_pkg::REQ_ALLOC;
      end else begin
         kind = $urandom_range(1) ? lsa_pkg::REQ_TOUCH : lsa_pkg::REQ_RELEASE;
         if (held_total > 0 && $urandom_range(9) < 8) begin
            id = lru_stack[$urandom_range(held_total - 1)];
         end
      end
      return make_req(kind, id);
   endfunction

   function automatic void flag_mismatch(string msg);
      if (mismatch_count < 10) $display("%s", msg);
      mismatch_count++;
   endfunction

   always @(posedge clock) begin : check_results
      lsa_pkg::lsa_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outcome_wr == outcome_rd) begin
            flag_mismatch($sformatf("result beat with nothing outstanding: status %0d slot %0d",
                                    rsp_data.status, rsp_data.granted_slot));
         end else begin
            want = take_outcome();
            if (rsp_data.status !== want.status)
               flag_mismatch($sformatf("status: expected %0d, got %0d",
                                       want.status, rsp_data.status));
            if (rsp_data.granted_slot !== want.granted_slot)
               flag_mismatch($sformatf("granted_slot: expected %0d, got %0d",
                                       want.granted_slot, rsp_data.granted_slot));
            if (rsp_data.evicted !== want.evicted)
               flag_mismatch($sformatf("evicted: expected %0d, got %0d",
                                       want.evicted, rsp_data.evicted));
         end
      end
   end

   // Start is left high after acceptance so that back-to-back requests need not lower it in between.
   task automatic send_request(lsa_pkg::lsa_req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      store_outcome(predict_outcome(r));
   endtask

   task automatic pause(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (outcome_wr != outcome_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_pool_size(logic [lsa_pkg::ACTIVE_W-1:0] value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_size = value;
   endtask

   task automatic test_basic_requests();
      send_request(make_req(lsa_pkg::REQ_TOUCH, 6'd5));
      send_request(make_req(lsa_pkg::REQ_RELEASE, 6'd63));
      send_request(make_req(REQ_UNUSED, 6'd63));
      send_request(make_req(REQ_UNUSED, 6'd0));
      send_request(make_req(lsa_pkg::REQ_ALLOC, 6'd63));
      send_request(make_req(lsa_pkg::REQ_ALLOC, 6'd0));
      send_request(make_req(lsa_pkg::REQ_ALLOC, 6'd42));
      send_request(make_req(lsa_pkg::REQ_ALLOC, 6'd21));
      send_request(make_req(lsa_pkg::REQ_TOUCH, 6'd0));
      send_request(make_req(lsa_pkg::REQ_RELEASE, 6'd2));
      send_request(make_req(lsa_pkg::REQ_ALLOC, 6'd0));
      send_request(make_req(lsa_pkg::REQ_TOUCH, 6'd63));
      send_request(make_req(lsa_pkg::REQ_RELEASE, 6'd1));
      send_request(make_req(lsa_pkg::REQ_RELEASE, 6'd1));
      send_request(make_req(lsa_pkg::REQ_TOUCH, 6'd3));
   endtask

   // Held slots above a shrunken pool are still reclaimed, and an empty pool of size zero
   // has nothing to give.
   task automatic test_reduced_pool();
      set_pool_size(7'd1);
      repeat (3) send_request(make_req(lsa_pkg::REQ_ALLOC, 6'd0));
      while (held_total > 0)
         send_request(make_req(lsa_pkg::REQ_RELEASE, lru_stack[held_total - 1]));
      set_pool_size(7'd0);
      send_request(make_req(lsa_pkg::REQ_ALLOC, 6'd63));
      send_request(make_req(lsa_pkg::REQ_TOUCH, 6'd0));
      set_pool_size(7'd127);
   endtask

   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned n;
      int unsigned alloc_pct;
      logic [lsa_pkg::ACTIVE_W-1:0] size;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: size = 7'd64;
            1: size = 7'd127;
            2: size = 7'd1;
            3: size = 7'd0;
            4: size = 7'd2;
            5: size = 7'd63;
            default: size = lsa_pkg::ACTIVE_W'($urandom_range(1, lsa_pkg::NUM_SLOTS));
         endcase
         set_pool_size(size);
         alloc_pct = (phase == 0) ? 90 : $urandom_range(25, 80);
         for (n = 0; n < 125; n++) begin
            send_request(random_request(alloc_pct));
            if ($urandom_range(7) == 0) pause($urandom_range(1, 11));
         end
      end
   endtask

   task automatic test_back_to_back();
      int unsigned n;
      set_pool_size(lsa_pkg::ACTIVE_W'($urandom_range(1, lsa_pkg::NUM_SLOTS)));
      for (n = 0; n < 200; n++) begin
         send_request(random_request(55));
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      held_total = 0;
      slot_held  = '0;
      pool_size  = lsa_pkg::ACTIVE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_requests();
      test_reduced_pool();
      test_random_traffic();
      test_back_to_back();
      wait_for_results();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
